// ===== rtl/ards_pkg.sv =====
package ards_pkg;

  // request fields as they arrive on the command channel
  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  target;
    logic [15:0] alarm_id;
    logic [1:0]  alarm_type;
  } req_t;

  // result fields, one result per request
  typedef struct packed {
    logic [7:0] warn_mask;
    logic [7:0] err_mask;
    logic [7:0] pushed_mask;
    logic       flag_bit;
    logic [1:0] status;
  } rsp_t;

  // request kinds
  localparam logic [1:0] REQ_REGISTER  = 2'd0;
  localparam logic [1:0] REQ_RESET_ALL = 2'd1;
  localparam logic [1:0] REQ_READ      = 2'd2;

  // alarm kinds
  localparam logic [1:0] TYPE_WARN = 2'd1;
  localparam logic [1:0] TYPE_ERR  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;
  localparam logic [1:0] ST_NO_AXIS = 2'd3;

  // low id bits select the bit inside one bitmap word
  localparam logic [15:0] BIT_LOW_MASK = 16'h000F;

endpackage

// ===== rtl/ards_ram.sv =====
module ards_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // single write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/alarm_register_dedup_stack_top.sv =====
// Per-axis alarm log with duplicate-free id stacks and a sticky per-axis bitmap.
// Command channel: a request (req_i) is taken when start is high and busy is low.
// Its single result appears on rsp_o for exactly one cycle with rsp_valid_o high;
// the receiver cannot stall, so the result is never held back.
// Configuration channel: cfg_data_i sets the manager enable bit on a cycle where
// cfg_valid_i and cfg_ready_o are both high; cfg_ready_o is always high.
// Steps from acceptance to the result strobe:
//   register: for each targeted axis in turn, a flag update, a duplicate scan
//             of that axis's stack, then a push and a bitmap write if the id
//             is new, nonzero and the stack is not full; the duplicate scan
//             reads one stack entry per cycle from the stack RAM
//   read: one bitmap RAM read
// busy stays high from acceptance until the result cycle has passed.
// After reset the bitmap RAM, AXES times (MAX_ALARM/16 + 1) words (32 with the
// defaults), is cleared one word per cycle with busy held high; stacks, fill
// counts, flags and the enable bit are cleared at once.
module alarm_register_dedup_stack_top #(
  parameter int AXES        = 2,
  parameter int STACK_DEPTH = 16,
  parameter int MAX_ALARM   = 255
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  ards_pkg::req_t  req_i,
  output logic            rsp_valid_o,
  output ards_pkg::rsp_t  rsp_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic            cfg_data_i
);

  localparam int WORDS       = (MAX_ALARM >> 4) + 1;
  localparam int STK_ENTRIES = AXES * STACK_DEPTH;
  localparam int BM_ENTRIES  = AXES * WORDS;
  localparam int AXW = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int TW  = $clog2(STACK_DEPTH + 1);
  localparam int KW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int IDW = $clog2(MAX_ALARM + 1);
  localparam int WW  = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int SAW = (STK_ENTRIES > 1) ? $clog2(STK_ENTRIES) : 1;
  localparam int BAW = (BM_ENTRIES > 1) ? $clog2(BM_ENTRIES) : 1;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_FLAG   = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;
  localparam logic [2:0] S_BMWR   = 3'd5;
  localparam logic [2:0] S_READ   = 3'd6;
  localparam logic [2:0] S_RESP   = 3'd7;

  logic [2:0]      state_q;
  logic            en_q;
  logic [AXES-1:0] warn_q;
  logic [AXES-1:0] err_q;
  logic [AXES-1:0] pushed_q;
  logic [TW-1:0]   top_q [AXES];
  logic [AXW-1:0]  axis_q;
  logic [AXW-1:0]  last_q;
  logic [TW-1:0]   k_q;
  logic            pend_q;
  logic            dup_q;
  logic [BAW-1:0]  clr_q;
  logic            flag_q;
  logic [1:0]      status_q;
  logic [IDW-1:0]  id_q;
  logic [1:0]      atype_q;

  logic [TW-1:0]   top_cur;
  logic            scan_rd;
  logic            push_ok;
  logic            last_axis;
  logic            req_bad;
  logic [AXW-1:0]  req_ax;
  logic [SAW-1:0]  stk_base;
  logic [BAW-1:0]  bm_reg_addr;
  logic [BAW-1:0]  bm_req_addr;
  logic [WW-1:0]   reg_word;
  logic [WW-1:0]   req_word;

  logic            stk_we;
  logic [SAW-1:0]  stk_waddr;
  logic [SAW-1:0]  stk_raddr;
  logic [IDW-1:0]  stk_rdata;
  logic            bm_we;
  logic [BAW-1:0]  bm_waddr;
  logic [15:0]     bm_wdata;
  logic [BAW-1:0]  bm_raddr;
  logic [15:0]     bm_rdata;

  // request decode
  assign req_ax  = AXW'(req_i.target - 4'd1);
  assign req_bad = (req_i.target > 4'(AXES)) || (req_i.alarm_id > 16'(MAX_ALARM));

  // per-axis working values
  assign top_cur   = top_q[axis_q];
  assign scan_rd   = (state_q == S_SCAN) && (k_q < top_cur);
  assign push_ok   = !dup_q && (top_cur < TW'(STACK_DEPTH)) && (id_q != '0);
  assign last_axis = (axis_q == last_q);

  // memory addresses
  assign stk_base    = SAW'(axis_q * STACK_DEPTH);
  assign reg_word    = WW'(id_q >> 4);
  assign req_word    = WW'((req_i.alarm_id & ~ards_pkg::BIT_LOW_MASK) >> 4);
  assign bm_reg_addr = BAW'(axis_q * WORDS) + BAW'(reg_word);
  assign bm_req_addr = BAW'(req_ax * WORDS) + BAW'(req_word);

  // stack ram port control
  always_comb begin
    stk_we    = (state_q == S_DECIDE) && push_ok;
    stk_waddr = stk_base + SAW'(top_cur[KW-1:0]);
    stk_raddr = stk_base + SAW'(k_q[KW-1:0]);
  end

  // bitmap ram port control, clearing pass has the write port after reset
  always_comb begin
    bm_we    = (state_q == S_CLEAR) || (state_q == S_BMWR);
    bm_waddr = (state_q == S_CLEAR) ? clr_q : bm_reg_addr;
    bm_wdata = (state_q == S_CLEAR) ? 16'h0000 : (bm_rdata | (16'h0001 << id_q[3:0]));
    bm_raddr = (state_q == S_IDLE) ? bm_req_addr : bm_reg_addr;
  end

  ards_ram #(
    .DEPTH (STK_ENTRIES),
    .WIDTH (IDW)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (id_q),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  ards_ram #(
    .DEPTH (BM_ENTRIES),
    .WIDTH (16)
  ) u_bitmap_ram (
    .clk_i   (clk_i),
    .we_i    (bm_we),
    .waddr_i (bm_waddr),
    .wdata_i (bm_wdata),
    .raddr_i (bm_raddr),
    .rdata_o (bm_rdata)
  );

  // request payload capture
  always_ff @(posedge clk_i) begin
    if ((state_q == S_IDLE) && start) begin
      id_q    <= req_i.alarm_id[IDW-1:0];
      atype_q <= req_i.alarm_type;
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      en_q     <= 1'b0;
      warn_q   <= '0;
      err_q    <= '0;
      pushed_q <= '0;
      top_q    <= '{default: '0};
      axis_q   <= '0;
      last_q   <= '0;
      k_q      <= '0;
      pend_q   <= 1'b0;
      dup_q    <= 1'b0;
      clr_q    <= '0;
      flag_q   <= 1'b0;
      status_q <= ards_pkg::ST_DONE;
    end else begin
      if (cfg_valid_i) begin
        en_q <= cfg_data_i;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + BAW'(1);
          if (clr_q == BAW'(BM_ENTRIES - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            pushed_q <= '0;
            flag_q   <= 1'b0;
            unique case (req_i.req_type)
              ards_pkg::REQ_REGISTER: begin
                if (!en_q) begin
                  status_q <= ards_pkg::ST_IGNORED;
                  state_q  <= S_RESP;
                end else if (req_bad) begin
                  status_q <= ards_pkg::ST_RANGE;
                  state_q  <= S_RESP;
                end else begin
                  status_q <= ards_pkg::ST_DONE;
                  axis_q   <= (req_i.target == 4'd0) ? '0 : req_ax;
                  last_q   <= (req_i.target == 4'd0) ? AXW'(AXES - 1) : req_ax;
                  state_q  <= S_FLAG;
                end
              end
              ards_pkg::REQ_RESET_ALL: begin
                state_q <= S_RESP;
                if (en_q) begin
                  status_q <= ards_pkg::ST_IGNORED;
                end else begin
                  status_q <= ards_pkg::ST_DONE;
                  warn_q   <= '0;
                  err_q    <= '0;
                  top_q    <= '{default: '0};
                end
              end
              ards_pkg::REQ_READ: begin
                if (req_i.target == 4'd0) begin
                  status_q <= ards_pkg::ST_NO_AXIS;
                  state_q  <= S_RESP;
                end else if (req_bad) begin
                  status_q <= ards_pkg::ST_RANGE;
                  state_q  <= S_RESP;
                end else begin
                  status_q <= ards_pkg::ST_DONE;
                  state_q  <= S_READ;
                end
              end
              default: begin
                status_q <= ards_pkg::ST_IGNORED;
                state_q  <= S_RESP;
              end
            endcase
          end
        end
        S_FLAG: begin
          if (atype_q == ards_pkg::TYPE_WARN) begin
            warn_q[axis_q] <= 1'b1;
          end else if (atype_q == ards_pkg::TYPE_ERR) begin
            err_q[axis_q] <= 1'b1;
          end
          k_q     <= '0;
          pend_q  <= 1'b0;
          dup_q   <= 1'b0;
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          // one entry read per cycle, compared as its data returns
          k_q    <= k_q + TW'(scan_rd);
          pend_q <= scan_rd;
          if (pend_q && (stk_rdata == id_q)) begin
            dup_q <= 1'b1;
          end
          if (!scan_rd && !pend_q) begin
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (push_ok) begin
            top_q[axis_q]    <= top_cur + TW'(1);
            pushed_q[axis_q] <= 1'b1;
            state_q          <= S_BMWR;
          end else if (last_axis) begin
            state_q <= S_RESP;
          end else begin
            axis_q  <= axis_q + AXW'(1);
            state_q <= S_FLAG;
          end
        end
        S_BMWR: begin
          if (last_axis) begin
            state_q <= S_RESP;
          end else begin
            axis_q  <= axis_q + AXW'(1);
            state_q <= S_FLAG;
          end
        end
        S_READ: begin
          flag_q  <= bm_rdata[id_q[3:0]];
          state_q <= S_RESP;
        end
        S_RESP: begin
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // result and handshake outputs
  assign busy        = (state_q != S_IDLE);
  assign rsp_valid_o = (state_q == S_RESP);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    rsp_o.warn_mask   = 8'(warn_q);
    rsp_o.err_mask    = 8'(err_q);
    rsp_o.pushed_mask = 8'(pushed_q);
    rsp_o.flag_bit    = flag_q;
    rsp_o.status      = status_q;
  end

endmodule
